// File: src/bda_pkg.sv
// Shared constants, types and the state encoding of the bin density accumulator.
package bda_pkg;

	localparam int GRID_BINS   = 256;
	localparam int IDX_W       = $clog2(GRID_BINS + 1);
	localparam int STORE_DEPTH = GRID_BINS * GRID_BINS;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int COORD_W     = 32;
	localparam int NUM_W       = COORD_W + 2;
	localparam int EDGE_W      = COORD_W + IDX_W;
	localparam int DENS_W      = 64;
	localparam int CNT_W       = 17;
	localparam int CFG_ADDR_W  = 8;

	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] REG_BIN_WIDTH  = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BIN_HEIGHT = 8'd1;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_DIV,
		S_SPAN,
		S_COL,
		S_RD,
		S_MUL,
		S_WR,
		S_RRD,
		S_RWT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic               start;
		logic [NUM_W-1:0]   num;
		logic [COORD_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [NUM_W-1:0]   quo;
		logic [COORD_W-1:0] rem;
	} div_rsp_t;

endpackage

// File: src/bda_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bda_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65536
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/bda_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module bda_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bda_pkg::div_req_t req,
	output bda_pkg::div_rsp_t rsp
);

	localparam int CW = $clog2(bda_pkg::NUM_W + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [bda_pkg::NUM_W-1:0]   num_q;
	logic [bda_pkg::COORD_W-1:0] rem_q;
	logic [bda_pkg::COORD_W-1:0] den_q;
	logic [bda_pkg::COORD_W:0]   trial;
	logic [bda_pkg::COORD_W:0]   diff;
	logic                        qbit;

	assign trial = {rem_q, num_q[bda_pkg::NUM_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(bda_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[bda_pkg::NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[bda_pkg::COORD_W-1:0] : trial[bda_pkg::COORD_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;
	assign rsp.rem  = rem_q;

endmodule

// File: src/bin_density_accumulator.sv
// Top level of the bin density accumulator: sequencer, bin walk and store.
//
// Usage:
//  - Input channel (s_*): one transfer carries one item. s_tuser is the mode:
//    0 adds a rectangle to the density map, 1 reads one bin total.
//  - Output channel (m_*): exactly one result transfer per input item.
//  - Config port: cfg_we writes cfg_wdata to register cfg_addr (0 bin width,
//    1 bin height), only while the block is idle: a user rule, not enforced.
//    Zero sizes act as one.
// Timing:
//  - Reset starts a clearing pass that zeroes all GRID_BINS^2 totals, one per
//    cycle; s_tready stays low until it ends.
//  - A read raises m_tvalid after S_RRD, S_RWT (in grid only) and S_FIN.
//  - An add runs four divisions on the one shared divider, then walks the
//    covered bins: a column step per column plus read, multiply and write
//    back per bin. The shared divider and the store walk set the rate.
//  - Items are taken one at a time; s_tready is high only when idle.
//  - The result sits in an output register; a stalled receiver holds it while
//    the next item is already taken and worked on. A finished result waits
//    for the output register to free up.
module bin_density_accumulator (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: rect_x[31:0], rect_y[63:32], rect_width[95:64],
	//          rect_height[127:96], bin_col[135:128], bin_row[143:136]
	input  logic [143:0]                      s_tdata,
	// s_tuser: mode[0]
	input  logic                              s_tuser,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// m_tdata: density[63:0], bins_updated[80:64], saturated[81], zero pad
	output logic [87:0]                       m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_we,
	input  logic [bda_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [31:0]                       cfg_wdata
);

	localparam int CW = bda_pkg::COORD_W;
	localparam int EW = bda_pkg::EDGE_W;
	localparam int IW = bda_pkg::IDX_W;
	localparam int AW = bda_pkg::ADDR_W;
	localparam int DW = bda_pkg::DENS_W;
	localparam int NW = bda_pkg::NUM_W;
	localparam int KW = bda_pkg::CNT_W;

	// overlap of [a1,a2) with [b1,b2); callers guarantee it fits one bin size
	function automatic logic [CW-1:0] overlap(input logic [EW-1:0] a1,
		input logic [EW-1:0] a2, input logic [EW-1:0] b1, input logic [EW-1:0] b2);
		logic [EW-1:0] hi;
		logic [EW-1:0] lo;
		logic [EW-1:0] d;
		hi = (a2 < b2) ? a2 : b2;
		lo = (a1 > b1) ? a1 : b1;
		d  = hi - lo;
		return (hi > lo) ? d[CW-1:0] : '0;
	endfunction

	// clamp a quotient to the grid edge
	function automatic logic [IW-1:0] clamp_idx(input logic [NW-1:0] q);
		return (q > NW'(bda_pkg::GRID_BINS)) ? IW'(bda_pkg::GRID_BINS) : q[IW-1:0];
	endfunction

	bda_pkg::state_t state_q, state_d;

	// config
	logic [CW-1:0] bin_width_q, bin_height_q;
	logic [CW-1:0] bw, bh;

	// latched item
	logic          mode_q;
	logic [CW-1:0] x1_q, y1_q;
	logic [CW:0]   x2_q, y2_q;
	logic [7:0]    col_q, row_q;

	// span and walk
	logic [1:0]    div_idx_q;
	logic          div_run_q;
	logic [IW-1:0] lx_q, ly_q, ux_q, uy_q;
	logic [IW-1:0] j_q, k_q;
	logic [CW-1:0] ex0_q, ey0_q;
	logic [EW-1:0] ex_q, ey_q;
	logic [CW-1:0] ox_q, oy_q;
	logic [DW-1:0] area_q;
	logic [KW-1:0] cnt_q;
	logic          sat_q;
	logic [DW-1:0] dens_q;
	logic [AW-1:0] clr_q;

	// output register
	logic          m_valid_q;
	logic [87:0]   m_data_q;

	// datapath
	bda_pkg::div_req_t div_req;
	bda_pkg::div_rsp_t div_rsp;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr, bin_addr, rd_addr;
	logic [DW-1:0] ram_wdata, ram_rdata;
	logic [DW:0]   sum;
	logic          in_grid;
	logic          accept, slot_free;

	assign bw = (bin_width_q == '0) ? CW'(1) : bin_width_q;
	assign bh = (bin_height_q == '0) ? CW'(1) : bin_height_q;

	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_valid_q || m_tready;
	assign bin_addr  = AW'(j_q) * AW'(bda_pkg::GRID_BINS) + AW'(k_q);
	assign rd_addr   = AW'(col_q) * AW'(bda_pkg::GRID_BINS) + AW'(row_q);
	assign in_grid   = ({24'd0, col_q} < 32'(bda_pkg::GRID_BINS)) &&
		({24'd0, row_q} < 32'(bda_pkg::GRID_BINS));
	assign sum       = {1'b0, ram_rdata} + {1'b0, area_q};

	// divider operand select: low edges floor, high edges ceiling
	always_comb begin
		div_req.start = (state_q == bda_pkg::S_DIV) && !div_run_q;
		case (div_idx_q)
			2'd0: begin
				div_req.num = NW'(x1_q);
				div_req.den = bw;
			end
			2'd1: begin
				div_req.num = NW'(y1_q);
				div_req.den = bh;
			end
			2'd2: begin
				div_req.num = NW'(x2_q) + NW'(bw) - NW'(1);
				div_req.den = bw;
			end
			default: begin
				div_req.num = NW'(y2_q) + NW'(bh) - NW'(1);
				div_req.den = bh;
			end
		endcase
	end

	bda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bda_ram #(
		.WIDTH (DW),
		.DEPTH (bda_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state and control outputs
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = bin_addr;
		ram_wdata = sum[DW] ? '1 : sum[DW-1:0];
		ram_raddr = bin_addr;
		case (state_q)
			bda_pkg::S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(bda_pkg::STORE_DEPTH - 1)) begin
					state_d = bda_pkg::S_IDLE;
				end
			end
			bda_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser == bda_pkg::MODE_READ) ? bda_pkg::S_RRD
						: bda_pkg::S_DIV;
				end
			end
			bda_pkg::S_DIV: begin
				if (div_rsp.done && div_idx_q == 2'd3) begin
					state_d = bda_pkg::S_SPAN;
				end
			end
			bda_pkg::S_SPAN: begin
				state_d = (lx_q < ux_q && ly_q < uy_q) ? bda_pkg::S_COL : bda_pkg::S_FIN;
			end
			bda_pkg::S_COL: begin
				state_d = bda_pkg::S_RD;
			end
			bda_pkg::S_RD: begin
				ram_re  = 1'b1;
				state_d = bda_pkg::S_MUL;
			end
			bda_pkg::S_MUL: begin
				state_d = bda_pkg::S_WR;
			end
			bda_pkg::S_WR: begin
				ram_we = 1'b1;
				if (k_q + IW'(1) < uy_q) begin
					state_d = bda_pkg::S_RD;
				end else if (j_q + IW'(1) < ux_q) begin
					state_d = bda_pkg::S_COL;
				end else begin
					state_d = bda_pkg::S_FIN;
				end
			end
			bda_pkg::S_RRD: begin
				ram_raddr = rd_addr;
				ram_re    = in_grid;
				state_d   = in_grid ? bda_pkg::S_RWT : bda_pkg::S_FIN;
			end
			bda_pkg::S_RWT: begin
				state_d = bda_pkg::S_FIN;
			end
			bda_pkg::S_FIN: begin
				if (slot_free) begin
					state_d = bda_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bda_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bda_pkg::S_CLR;
			clr_q        <= '0;
			bin_width_q  <= 32'd256;
			bin_height_q <= 32'd256;
			div_idx_q    <= '0;
			div_run_q    <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bda_pkg::S_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we && cfg_addr == bda_pkg::REG_BIN_WIDTH) begin
				bin_width_q <= cfg_wdata;
			end
			if (cfg_we && cfg_addr == bda_pkg::REG_BIN_HEIGHT) begin
				bin_height_q <= cfg_wdata;
			end
			if (div_req.start) begin
				div_run_q <= 1'b1;
			end else if (div_rsp.done) begin
				div_run_q <= 1'b0;
				div_idx_q <= div_idx_q + 2'd1;
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == bda_pkg::S_FIN && slot_free) begin
				m_valid_q <= 1'b1;
			end
		end
	end

	// datapath registers, sequenced by state
	always_ff @(posedge clk) begin
		case (state_q)
			bda_pkg::S_IDLE: begin
				if (accept) begin
					mode_q <= s_tuser;
					x1_q   <= s_tdata[31:0];
					y1_q   <= s_tdata[63:32];
					x2_q   <= {1'b0, s_tdata[31:0]} + {1'b0, s_tdata[95:64]};
					y2_q   <= {1'b0, s_tdata[63:32]} + {1'b0, s_tdata[127:96]};
					col_q  <= s_tdata[135:128];
					row_q  <= s_tdata[143:136];
					cnt_q  <= '0;
					sat_q  <= 1'b0;
					dens_q <= '0;
				end
			end
			bda_pkg::S_DIV: begin
				if (div_rsp.done) begin
					case (div_idx_q)
						2'd0: begin
							lx_q  <= clamp_idx(div_rsp.quo);
							ex0_q <= x1_q - div_rsp.rem;
						end
						2'd1: begin
							ly_q  <= clamp_idx(div_rsp.quo);
							ey0_q <= y1_q - div_rsp.rem;
						end
						2'd2: ux_q <= clamp_idx(div_rsp.quo);
						default: uy_q <= clamp_idx(div_rsp.quo);
					endcase
				end
			end
			bda_pkg::S_SPAN: begin
				j_q  <= lx_q;
				ex_q <= EW'(ex0_q);
			end
			bda_pkg::S_COL: begin
				ox_q <= overlap(EW'(x1_q), EW'(x2_q), ex_q, ex_q + EW'(bw));
				k_q  <= ly_q;
				ey_q <= EW'(ey0_q);
			end
			bda_pkg::S_RD: begin
				oy_q <= overlap(EW'(y1_q), EW'(y2_q), ey_q, ey_q + EW'(bh));
			end
			bda_pkg::S_MUL: begin
				area_q <= DW'(ox_q) * DW'(oy_q);
			end
			bda_pkg::S_WR: begin
				cnt_q <= cnt_q + KW'(1);
				if (sum[DW]) begin
					sat_q <= 1'b1;
				end
				if (k_q + IW'(1) < uy_q) begin
					k_q  <= k_q + IW'(1);
					ey_q <= ey_q + EW'(bh);
				end else begin
					j_q  <= j_q + IW'(1);
					ex_q <= ex_q + EW'(bw);
				end
			end
			bda_pkg::S_RWT: begin
				dens_q <= ram_rdata;
				sat_q  <= (ram_rdata == '1);
			end
			bda_pkg::S_FIN: begin
				if (slot_free) begin
					m_data_q <= {6'd0, sat_q, cnt_q, dens_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// a write-back always follows its multiply step
	a_wr_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bda_pkg::S_WR |-> $past(state_q) == bda_pkg::S_MUL)
		else $error("write-back without multiply step");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == bda_pkg::S_DIV)
		else $error("divider done outside division phase");

	// the walk stays inside the clamped span
	a_walk_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bda_pkg::S_RD |-> (j_q < ux_q && k_q < uy_q && mode_q == bda_pkg::MODE_ADD))
		else $error("bin walk left the span");

	// an add never touches more bins than the grid holds
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bda_pkg::S_FIN |-> cnt_q <= KW'(bda_pkg::STORE_DEPTH))
		else $error("bin count beyond grid");

endmodule

// File: verif/bin_density_accumulator_test.sv
// Testbench for the bin density accumulator: stream stimulus, scoreboard and density map predictor.
`timescale 1ns / 1ps

module bin_density_accumulator_test;

	localparam longint unsigned CYCLE_LIMIT = 4_000_000;
	localparam longint unsigned ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [63:0] density;
		logic [16:0] bins_updated;
		logic        saturated;
	} bin_result_t;

	// Scoreboard: carries its own density map and bin size, predicts each
	// transfer's result and checks results in order.
	class bin_map_scoreboard;
		logic [31:0]      bin_w;
		logic [31:0]      bin_h;
		longint unsigned  totals[int];
		bin_result_t      pending_q[$];
		int               errors;
		int               adds;
		int               reads;
		int               clips;
		int               last_col;
		int               last_row;

		function void reset_map();
			totals.delete();
			pending_q.delete();
			bin_w = 32'd256;
			bin_h = 32'd256;
		endfunction

		function void write_reg(logic [bda_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] val);
			if (addr == bda_pkg::REG_BIN_WIDTH)
				bin_w = val;
			else if (addr == bda_pkg::REG_BIN_HEIGHT)
				bin_h = val;
		endfunction

		function longint unsigned overlap(longint unsigned a1, longint unsigned a2,
				longint unsigned b1, longint unsigned b2);
			longint unsigned hi;
			longint unsigned lo;
			hi = (a2 < b2) ? a2 : b2;
			lo = (a1 > b1) ? a1 : b1;
			return (hi > lo) ? hi - lo : 0;
		endfunction

		// Predict the result of one accepted input transfer.
		function void note_item(logic mode, logic [143:0] d);
			bin_result_t     r;
			longint unsigned bw, bh, x1, y1, x2, y2, lx, ly, ux, uy;
			longint unsigned ox, oy, cur, sum;
			int              idx;
			int              col, row;
			r.density = '0;
			r.bins_updated = '0;
			r.saturated = 1'b0;
			bw = (bin_w == 0) ? 1 : bin_w;
			bh = (bin_h == 0) ? 1 : bin_h;
			if (mode == bda_pkg::MODE_READ) begin
				reads++;
				col = d[135:128];
				row = d[143:136];
				if (col < bda_pkg::GRID_BINS && row < bda_pkg::GRID_BINS) begin
					idx = col * bda_pkg::GRID_BINS + row;
					cur = totals.exists(idx) ? totals[idx] : 0;
					r.density = cur;
					r.saturated = (cur == ALL_ONES);
				end
			end else begin
				adds++;
				x1 = d[31:0];
				y1 = d[63:32];
				x2 = x1 + d[95:64];
				y2 = y1 + d[127:96];
				lx = x1 / bw;
				ly = y1 / bh;
				ux = (x2 + bw - 1) / bw;
				uy = (y2 + bh - 1) / bh;
				if (ux > bda_pkg::GRID_BINS) ux = bda_pkg::GRID_BINS;
				if (uy > bda_pkg::GRID_BINS) uy = bda_pkg::GRID_BINS;
				if (lx < bda_pkg::GRID_BINS) last_col = lx;
				if (ly < bda_pkg::GRID_BINS) last_row = ly;
				for (longint unsigned j = lx; j < ux; j++) begin
					ox = overlap(x1, x2, j * bw, (j + 1) * bw);
					for (longint unsigned k = ly; k < uy; k++) begin
						oy = overlap(y1, y2, k * bh, (k + 1) * bh);
						idx = int'(j * bda_pkg::GRID_BINS + k);
						cur = totals.exists(idx) ? totals[idx] : 0;
						sum = cur + ox * oy;
						if (sum < cur) begin
							sum = ALL_ONES;
							r.saturated = 1'b1;
						end
						totals[idx] = sum;
						if (r.bins_updated != 17'h1FFFF) r.bins_updated++;
					end
				end
				if (r.saturated) clips++;
			end
			pending_q.push_back(r);
		endfunction

		function void check_result(logic [87:0] t);
			bin_result_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected result transfer: %h", t);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (t[63:0] !== e.density) begin
				$error("density: expected %h, got %h", e.density, t[63:0]);
				errors++;
			end
			if (t[80:64] !== e.bins_updated) begin
				$error("bins_updated: expected %0d, got %0d", e.bins_updated, t[80:64]);
				errors++;
			end
			if (t[81] !== e.saturated) begin
				$error("saturated: expected %0b, got %0b", e.saturated, t[81]);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic [143:0]                   s_tdata;
	logic                           s_tuser;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [87:0]                    m_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic                           cfg_we;
	logic [bda_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [31:0]                    cfg_wdata;

	bin_map_scoreboard sb;
	longint unsigned   cycles;
	int                burst_left;
	int                stall_mode;

	bin_density_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter doubles as the watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("bin_density_accumulator_test: FAIL");
			$finish;
		end
	end

	// Receiver: the stall pattern is drawn anew whenever the cycle count's low
	// byte is zero, among always ready, coin flip, and mostly stalled.
	always @(negedge clk) begin
		if (cycles[7:0] == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Result monitor; a transfer happens on valid and ready at the edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Send one item; the sender runs in bursts with random gaps in between.
	// Called at a falling edge, returns at a falling edge with s_tvalid still
	// up; the next call or drain() changes it in the same step.
	task automatic send_item(logic mode, logic [143:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tdata  <= d;
		s_tuser  <= mode;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_item(mode, d);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic add_rect(logic [31:0] x, logic [31:0] y, logic [31:0] w, logic [31:0] h);
		send_item(bda_pkg::MODE_ADD, {16'($urandom_range(0, 65535)), h, w, y, x});
	endtask

	task automatic read_bin(logic [7:0] col, logic [7:0] row);
		send_item(bda_pkg::MODE_READ, {row, col, {4{$urandom()}}});
	endtask

	// Hold the sender until every expected result is back, then let the
	// block settle so a register write lands on an idle block.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_bins(logic [31:0] w, logic [31:0] h);
		drain();
		cfg_we <= 1'b1; cfg_addr <= bda_pkg::REG_BIN_WIDTH; cfg_wdata <= w;
		@(negedge clk);
		cfg_addr <= bda_pkg::REG_BIN_HEIGHT; cfg_wdata <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(bda_pkg::REG_BIN_WIDTH, w);
		sb.write_reg(bda_pkg::REG_BIN_HEIGHT, h);
	endtask

	// Random phase. With small bins the rectangles span a few bins near the
	// grid; with huge bins any coordinate is cheap, so fields go fully random.
	task automatic random_phase(int n, bit wide_open);
		longint unsigned bw, bh;
		logic [31:0]     x, y, w, h;
		bw = (sb.bin_w == 0) ? 1 : sb.bin_w;
		bh = (sb.bin_h == 0) ? 1 : sb.bin_h;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 1) == 0)
					read_bin(8'(sb.last_col), 8'(sb.last_row));
				else
					read_bin(8'($urandom()), 8'($urandom()));
			end else if (wide_open) begin
				add_rect($urandom(), $urandom(), $urandom(), $urandom());
			end else begin
				x = 32'($urandom_range(0, 259) * bw + $urandom_range(0, bw - 1));
				y = 32'($urandom_range(0, 259) * bh + $urandom_range(0, bh - 1));
				w = 32'($urandom_range(0, 3) * bw + $urandom_range(0, bw - 1));
				h = 32'($urandom_range(0, 3) * bh + $urandom_range(0, bh - 1));
				if ($urandom_range(0, 15) == 0) w = 0;
				add_rect(x, y, w, h);
			end
		end
	endtask

	initial begin
		sb = new();
		sb.reset_map();
		cycles = 0;
		burst_left = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		s_tdata = '0;
		s_tuser = bda_pkg::MODE_ADD;
		s_tvalid = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = bda_pkg::REG_BIN_WIDTH;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Clearing pass runs first; the sender blocks on s_tready meanwhile.

		// Directed part at reset bin size (1.0 x 1.0).
		add_rect(32'd0, 32'd0, 32'd256, 32'd256);        // exactly one bin
		add_rect(32'd128, 32'd64, 32'd300, 32'd200);     // fractional, 2x2 bins
		add_rect(32'd512, 32'd512, 32'd0, 32'd300);      // zero width
		add_rect(32'd65536, 32'd0, 32'd256, 32'd256);    // span off the grid
		add_rect(32'd65280, 32'd65280, 32'd1000, 32'd1000); // clamped at the edge
		add_rect(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		read_bin(8'd0, 8'd0);
		read_bin(8'd1, 8'd1);
		read_bin(8'd255, 8'd255);
		add_rect(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // whole grid
		read_bin(8'd200, 8'd17);
		// Zero bin size acts as one.
		set_bins(32'd0, 32'd0);
		add_rect(32'd3, 32'd5, 32'd2, 32'd1);
		read_bin(8'd4, 8'd5);
		// Largest bins: three full bins of area drive one total to clip.
		set_bins(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		repeat (3) add_rect(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		read_bin(8'd0, 8'd0);
		add_rect(32'd0, 32'd0, 32'd1, 32'd1);
		read_bin(8'd0, 8'd0);

		// Random phases over several bin sizes.
		set_bins(32'd256, 32'd256);
		random_phase(250, 1'b0);
		set_bins(32'd1, 32'd1);
		random_phase(200, 1'b0);
		set_bins(32'd300, 32'd77);
		random_phase(200, 1'b0);
		set_bins($urandom_range(1, 4096), $urandom_range(1, 4096));
		random_phase(250, 1'b0);
		set_bins(32'd0, 32'd0);
		random_phase(150, 1'b0);
		set_bins(32'h8000_0000 | $urandom(), 32'h8000_0000 | $urandom());
		random_phase(250, 1'b1);
		set_bins(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_phase(200, 1'b1);

		drain();
		$display("covered %0d adds and %0d reads over seven bin sizes, %0d clipped adds",
			sb.adds, sb.reads, sb.clips);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("bin_density_accumulator_test: PASS");
		end else begin
			$display("bin_density_accumulator_test: FAIL");
		end
		$finish;
	end

endmodule
